### design/sitoa_pkg.sv
// Shared types and constants for the signed integer to decimal text converter.
`timescale 1ns / 1ps

package sitoa_pkg;

    localparam int VALUE_W     = 32;
    localparam int DIGIT_W     = 4;
    localparam int NUM_DIGITS  = 10;
    localparam int BCD_W       = NUM_DIGITS * DIGIT_W;
    localparam int DIGIT_IDX_W = $clog2(NUM_DIGITS);
    localparam int STEPS       = VALUE_W;
    localparam int STEP_CNT_W  = $clog2(STEPS);
    localparam int CHAR_W      = 8;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    // Top-level sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_EMIT
    } sitoa_state_t;

    // Result of the binary to BCD unit
    typedef struct packed {
        logic             done;
        logic [BCD_W-1:0] bcd;
    } sitoa_conv_t;

endpackage

### design/signed_int_to_decimal_ascii.sv
// Top level: signed 32-bit integer to decimal ASCII text, one character per output transfer.
//
// Input channel (in_valid/in_ready, value): one signed 32-bit integer per request.
// Output channel (out_valid/out_ready, character, last): the decimal text in
// reading order, '-' first for negative values, no leading zeros, last set on
// the final character. Zero gives the single character '0'.
// After the input request, the binary to BCD unit converts the magnitude,
// one magnitude bit per cycle; its registered done flag then loads the
// character sequencer, which moves the first character into the output
// register. Characters then leave one per cycle while out_ready is high; in_ready
// is high only while no conversion or character sequencing is under way, and
// it rises again as the final character enters the output register.
// A stalled receiver holds the current character in the output register and
// halts the sequencer. Reset clears all control state; the block is ready for
// a new request in the first cycle after reset.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [sitoa_pkg::VALUE_W-1:0] value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [sitoa_pkg::CHAR_W-1:0]   character,
    output logic                           last
);
    import sitoa_pkg::*;

    sitoa_state_t       state_reg, state_next;
    logic               neg_reg;
    logic [VALUE_W-1:0] mag;
    logic               accept;
    logic               conv_start;
    logic               emit_load;
    logic               emit_done;
    sitoa_conv_t        conv;

    assign accept = in_valid && in_ready;
    assign mag    = value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(value)) : VALUE_W'(value);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (accept)    state_next = ST_CONVERT;
            ST_CONVERT: if (conv.done) state_next = ST_EMIT;
            ST_EMIT:    if (emit_done) state_next = ST_IDLE;
            default:                   state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_ready   = 1'b0;
        conv_start = 1'b0;
        emit_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                conv_start = in_valid;
            end
            ST_CONVERT: emit_load = conv.done;
            ST_EMIT:    ;
            default:    ;
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Hold the sign of the accepted request
    always_ff @(posedge clk)
    begin
        if (accept)
            neg_reg <= value[VALUE_W-1];
    end

    sitoa_dabble u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .start (conv_start),
        .mag   (mag),
        .conv  (conv)
    );

    sitoa_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (emit_load),
        .negative  (neg_reg),
        .bcd       (conv.bcd),
        .done      (emit_done),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .character (character),
        .last      (last)
    );

endmodule

### design/sitoa_dabble.sv
// Iterative binary to BCD unit: one shift and add-3 correction per cycle.
`timescale 1ns / 1ps

module sitoa_dabble (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [sitoa_pkg::VALUE_W-1:0] mag,
    output sitoa_pkg::sitoa_conv_t        conv
);
    import sitoa_pkg::*;

    logic [VALUE_W-1:0]    mag_reg, mag_next;
    logic [BCD_W-1:0]      bcd_reg, bcd_next;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [BCD_W-1:0]      adj;

    // Add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5))
                adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            else
                adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W];
        end
    end

    // Load on start, then shift one magnitude bit into the digits per cycle
    always_comb
    begin
        mag_next  = mag_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            mag_next  = mag;
            bcd_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            bcd_next = {adj[BCD_W-2:0], mag_reg[VALUE_W-1]};
            mag_next = {mag_reg[VALUE_W-2:0], 1'b0};
            cnt_next = cnt_reg + STEP_CNT_W'(1);
            if (cnt_reg == STEP_CNT_W'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Hold working data
    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
    end

    assign conv.done = done_reg;
    assign conv.bcd  = bcd_reg;

endmodule

### design/sitoa_emit.sv
// Character sequencer: sign, then digits without leading zeros, into an output register.
`timescale 1ns / 1ps

module sitoa_emit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  logic                         negative,
    input  logic [sitoa_pkg::BCD_W-1:0]  bcd,
    output logic                         done,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [sitoa_pkg::CHAR_W-1:0] character,
    output logic                         last
);
    import sitoa_pkg::*;

    logic [BCD_W-1:0]       digits_reg, digits_next;
    logic [DIGIT_IDX_W-1:0] idx_reg, idx_next;
    logic                   sign_reg, sign_next;
    logic                   active_reg, active_next;
    logic                   valid_reg, valid_next;
    logic [CHAR_W-1:0]      char_reg, char_next;
    logic                   last_reg, last_next;
    logic [DIGIT_IDX_W-1:0] top_idx;
    logic [DIGIT_W-1:0]     cur_digit;
    logic                   issue;

    // Find the most significant nonzero digit, or the units digit for zero
    always_comb
    begin
        top_idx = '0;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd[i*DIGIT_W +: DIGIT_W] != '0)
                top_idx = DIGIT_IDX_W'(i);
        end
    end

    assign cur_digit = digits_reg[idx_reg*DIGIT_W +: DIGIT_W];
    assign issue     = active_reg && (!valid_reg || out_ready);
    assign done      = issue && !sign_reg && (idx_reg == '0);

    // Advance through sign and digits, one character per free output slot
    always_comb
    begin
        digits_next = digits_reg;
        idx_next    = idx_reg;
        sign_next   = sign_reg;
        active_next = active_reg;
        char_next   = char_reg;
        last_next   = last_reg;
        valid_next  = valid_reg && !out_ready;
        if (load)
        begin
            digits_next = bcd;
            idx_next    = top_idx;
            sign_next   = negative;
            active_next = 1'b1;
        end
        else if (issue)
        begin
            valid_next = 1'b1;
            if (sign_reg)
            begin
                char_next = CHAR_MINUS;
                last_next = 1'b0;
                sign_next = 1'b0;
            end
            else
            begin
                char_next = CHAR_ZERO + CHAR_W'(cur_digit);
                last_next = (idx_reg == '0);
                if (idx_reg == '0)
                    active_next = 1'b0;
                else
                    idx_next = idx_reg - DIGIT_IDX_W'(1);
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
            sign_reg   <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            valid_reg  <= valid_next;
            sign_reg   <= sign_next;
            idx_reg    <= idx_next;
        end
    end

    // Hold digits and the output payload
    always_ff @(posedge clk)
    begin
        digits_reg <= digits_next;
        char_reg   <= char_next;
        last_reg   <= last_next;
    end

    assign out_valid = valid_reg;
    assign character = char_reg;
    assign last      = last_reg;

endmodule

### design/sitoa_checker.sv
// Port-level checks for the integer to decimal text converter, bound to the top level.
`timescale 1ns / 1ps

module sitoa_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic signed [sitoa_pkg::VALUE_W-1:0] value,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [sitoa_pkg::CHAR_W-1:0]   character,
    input logic                           last
);
    import sitoa_pkg::*;

    // A stalled character holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(character) && $stable(last))
        else $error("output character changed while stalled");

    // No new request while a conversion runs
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after a request");

    // A number is fully sequenced before the next request is taken
    a_mid_number_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !in_ready)
        else $error("input ready in the middle of a number");

    // Nothing appears at the output right after a fresh request
    a_no_early_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("output appeared before conversion finished");

    // A minus sign never ends a number
    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (character == CHAR_MINUS) |-> !last)
        else $error("minus sign flagged as last character");

endmodule

bind signed_int_to_decimal_ascii sitoa_checker u_checker (.*);

### tb/sv/tb_signed_int_to_decimal_ascii.sv
// Testbench for the signed integer to decimal ASCII converter.
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii;

    import sitoa_pkg::*;

    // One character of the expected decimal text
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last_flag;
    } text_char_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic signed [VALUE_W-1:0] value = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [CHAR_W-1:0]         character;
    logic                      last;

    logic [VALUE_W-1:0] pending_values[$];
    text_char_t         expected_chars[$];
    int                 error_count = 0;
    int                 send_gap = 0;
    int                 recv_gap = 0;
    logic               no_idle = 1'b0;
    logic               rx_hold = 1'b0;

    signed_int_to_decimal_ascii dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .character (character),
        .last      (last)
    );

    always #5 clk = ~clk;

    // Append the decimal text of one integer to the expected characters
    task automatic predict_text(input logic [VALUE_W-1:0] word);
        logic [VALUE_W-1:0] mag;
        logic [VALUE_W-1:0] digit;
        logic [CHAR_W-1:0]  digits[$];
        text_char_t         entry;
        mag = word[VALUE_W-1] ? (32'd0 - word) : word;
        do
        begin
            digit = mag % 32'd10;
            digits.push_front(CHAR_ZERO + digit[CHAR_W-1:0]);
            mag = mag / 32'd10;
        end
        while (mag != 32'd0);
        // Negative numbers always carry at least one digit after the sign
        if (word[VALUE_W-1])
        begin
            entry.ch        = CHAR_MINUS;
            entry.last_flag = 1'b0;
            expected_chars.push_back(entry);
        end
        for (int i = 0; i < digits.size(); i++)
        begin
            entry.ch        = digits[i];
            entry.last_flag = (i == digits.size() - 1);
            expected_chars.push_back(entry);
        end
    endtask

    // Draw a value spread over digit counts, signs and powers of ten
    function automatic logic [VALUE_W-1:0] draw_value();
        logic [VALUE_W-1:0] mag;
        logic [VALUE_W-1:0] scale;
        int                 kind;
        scale = 32'd1;
        kind  = $urandom_range(0, 4);
        case (kind)
            0: mag = $urandom();
            1:
            begin
                repeat ($urandom_range(1, 9)) scale = scale * 32'd10;
                mag = $urandom_range(0, scale - 1);
            end
            2:
            begin
                repeat ($urandom_range(0, 9)) scale = scale * 32'd10;
                mag = scale + $urandom_range(0, 2) - 32'd1;
            end
            3: mag = $urandom_range(0, 20);
            default:
            begin
                case ($urandom_range(0, 3))
                    0: mag = 32'h8000_0000;
                    1: mag = 32'h7FFF_FFFF;
                    2: mag = 32'h8000_0001;
                    default: mag = 32'h7FFF_FFFE;
                endcase
            end
        endcase
        if (kind >= 1 && kind <= 3 && $urandom_range(0, 1) == 1)
            mag = 32'd0 - mag;
        return mag;
    endfunction

    // Offer queued requests, with a random gap before each one
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predict_text(value);
                send_gap = no_idle ? 0 : $urandom_range(0, 16);
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_values.size() != 0)
                begin
                    value    <= pending_values.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Check each accepted character and stall the output at random
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_chars.size() == 0)
                begin
                    $error("unexpected character %h, last %b", character, last);
                    error_count++;
                end
                else
                begin
                    text_char_t exp_char;
                    exp_char = expected_chars.pop_front();
                    if (character !== exp_char.ch)
                    begin
                        $error("character: expected %h, got %h", exp_char.ch, character);
                        error_count++;
                    end
                    if (last !== exp_char.last_flag)
                    begin
                        $error("last: expected %b, got %b", exp_char.last_flag, last);
                        error_count++;
                    end
                end
                recv_gap = no_idle ? 0 : $urandom_range(0, 16);
            end
            if (rx_hold)
                out_ready <= 1'b0;
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Hold until every queued request is sent and all its text has come back
    task automatic drain();
        while (pending_values.size() != 0 || in_valid || expected_chars.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [VALUE_W-1:0] directed[$];
        directed = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99,
                     32'd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                     32'd1000000000, 32'd999999999, -32'sd999999999,
                     32'h5555_5555, 32'hAAAA_AAAA, 32'd1234567890, -32'sd1234567890,
                     32'd1000000, 32'd5, -32'sd5, -32'sd1000000000};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed values: extremes, zero, digit-count boundaries
        foreach (directed[i]) pending_values.push_back(directed[i]);
        drain();

        // Stall the receiver for a long stretch while requests keep coming
        for (int i = 0; i < 8; i++) pending_values.push_back(draw_value());
        rx_hold <= 1'b1;
        repeat (400) @(posedge clk);
        rx_hold <= 1'b0;
        drain();

        // Random values with idling on both sides
        for (int i = 0; i < 80; i++) pending_values.push_back(draw_value());
        drain();

        // Random values back to back with no idling
        no_idle <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < 50; i++) pending_values.push_back(draw_value());
        drain();
        no_idle <= 1'b0;
        @(posedge clk);

        // Full-range random values with idling again
        for (int i = 0; i < 25; i++) pending_values.push_back($urandom());
        drain();

        repeat (60) @(posedge clk);
        if (error_count == 0)
            $display("signed_int_to_decimal_ascii test passed");
        else
            $display("signed_int_to_decimal_ascii test failed");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #5_000_000;
        $display("signed_int_to_decimal_ascii test failed");
        $finish;
    end

endmodule

### files.f
design/sitoa_pkg.sv
design/sitoa_dabble.sv
design/sitoa_emit.sv
design/signed_int_to_decimal_ascii.sv
design/sitoa_checker.sv
tb/sv/tb_signed_int_to_decimal_ascii.sv
